>>> hw/rtl/tmds_palette_symbol_encoder_defines.svh
// Assertion macros shared by the TMDS palette symbol encoder RTL.
// Included by files that check their own logic; needs clk and rst_n in scope.
`ifndef TMDS_PALETTE_SYMBOL_ENCODER_DEFINES_SVH
`define TMDS_PALETTE_SYMBOL_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TPSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TPSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tpse_pkg.sv
// Shared types, constants and symbol functions for the TMDS palette encoder.
// No dependencies; used by tpse_word_builder and the top level.
`timescale 1ns / 1ps

package tpse_pkg;

    localparam int SYM_W  = 10;
    localparam int WORD_W = 62;

    // Fixed sync tokens
    localparam logic [SYM_W-1:0] TOK_A = 10'b1101010100;
    localparam logic [SYM_W-1:0] TOK_B = 10'b0010101011;
    localparam logic [SYM_W-1:0] TOK_C = 10'b0101010100;
    localparam logic [SYM_W-1:0] TOK_D = 10'b1010101011;

    // odd word = even word ^ mask (colors only)
    localparam logic [WORD_W-1:0] ODD_MASK = 62'h3_ffff_ffff_ffff;

    // tuser codes
    localparam logic KIND_COLOR = 1'b0;
    localparam logic KIND_CTRL  = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_INVERT_PAIRS   = 1'b0;
    localparam logic REG_RGB_LANE_ORDER = 1'b1;

    typedef struct packed {
        logic invert_pairs;
        logic rgb_lane_order;
    } cfg_t;

    // Transition-minimized 10-bit symbol, no DC balancing
    function automatic logic [SYM_W-1:0] tmds_symbol(input logic [7:0] din);
        logic [3:0]       ones;
        logic             use_xnor;
        logic [SYM_W-1:0] sym;
        ones = '0;
        for (int k = 0; k < 8; k++)
        begin
            ones = ones + {3'b000, din[k]};
        end
        use_xnor = (ones > 4'd4) || ((ones == 4'd4) && !din[0]);
        sym      = '0;
        sym[0]   = din[0];
        for (int k = 1; k < 8; k++)
        begin
            sym[k] = sym[k-1] ^ din[k] ^ use_xnor;
        end
        sym[8] = !use_xnor;
        sym[9] = use_xnor;
        return sym;
    endfunction

    function automatic logic [SYM_W-1:0] blue_token(input logic [1:0] code);
        logic [SYM_W-1:0] tok;
        unique case (code)
            2'd0:    tok = TOK_D;
            2'd1:    tok = TOK_C;
            2'd2:    tok = TOK_B;
            default: tok = TOK_A;
        endcase
        return tok;
    endfunction

    // Differential pair {~b, b}, optionally swapped
    function automatic logic [1:0] pair_bits(input logic b, input logic inv);
        return {~b, b} ^ {inv, inv};
    endfunction

endpackage

>>> hw/rtl/tpse_word_builder.sv
// Combinational symbol encode and pair serialization of one word.
// Depends on tpse_pkg.
`timescale 1ns / 1ps

module tpse_word_builder (
    input  logic                         kind,
    input  logic [23:0]                  color,
    input  logic [1:0]                   ctrl_code,
    input  tpse_pkg::cfg_t               cfg,
    output logic [tpse_pkg::WORD_W-1:0]  even_word,
    output logic [tpse_pkg::WORD_W-1:0]  odd_word
);
    import tpse_pkg::*;

    logic [SYM_W-1:0] sym_r;
    logic [SYM_W-1:0] sym_g;
    logic [SYM_W-1:0] sym_b;

    always_comb
    begin
        unique case (kind)
            KIND_COLOR:
            begin
                sym_r = tmds_symbol(color[23:16]);
                sym_g = tmds_symbol(color[15:8]);
                sym_b = tmds_symbol(color[7:0]);
            end
            default:
            begin
                sym_r = TOK_A;
                sym_g = TOK_A;
                sym_b = blue_token(ctrl_code);
            end
        endcase
    end

    // Symbol bit p -> 6-bit group; bits 9..5 in the upper half at 32, 4..0 at 0
    always_comb
    begin
        logic [5:0] six;
        even_word = '0;
        for (int p = 0; p < SYM_W; p++)
        begin
            if (cfg.rgb_lane_order)
                six = {pair_bits(sym_r[p], cfg.invert_pairs),
                       pair_bits(sym_g[p], cfg.invert_pairs),
                       pair_bits(sym_b[p], cfg.invert_pairs)};
            else
                six = {pair_bits(sym_b[p], cfg.invert_pairs),
                       pair_bits(sym_g[p], cfg.invert_pairs),
                       pair_bits(sym_r[p], cfg.invert_pairs)};
            if (p < 5)
                even_word[p*6 +: 6] = six;
            else
                even_word[32 + (p-5)*6 +: 6] = six;
        end
    end

    assign odd_word = (kind == KIND_COLOR) ? (even_word ^ ODD_MASK) : even_word;

endmodule

>>> hw/rtl/tmds_palette_symbol_encoder.sv
// Top level of the TMDS palette symbol encoder: stream ports, APB registers,
// input and result registers. Depends on tpse_pkg and tpse_word_builder.
`timescale 1ns / 1ps
`include "tmds_palette_symbol_encoder_defines.svh"

// Usage
//  Input stream (s_*): one word per color or sync token. s_tuser is the kind
//  (0 color, 1 control token); s_tdata[23:0] is the RGB888 color and
//  s_tdata[25:24] the control code.
//  Output stream (m_*): m_tdata[61:0] is the even word, m_tdata[123:62]
//  the odd word; upper bits are zero.
//  APB: address 0 invert_pairs, address 4 rgb_lane_order (bit 0 each).
//  Write registers only while the stream is idle.
// Pipeline / throughput
//  An accepted word goes into the input register, then through the symbol
//  encode and serializer logic into the result register and out on m_*.
//  One word per cycle is sustained while m_tready is high; the path is two register
//  stages deep with the encode cone between them.
// Reset
//  Both stages empty, invert_pairs = 0, rgb_lane_order = 1.
// Stall
//  With m_tready low the result holds; the input stage still takes one
//  more word, then s_tready drops until the result is taken.
module tmds_palette_symbol_encoder (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,    // color[23:0], ctrl_code[25:24], zero pad
    input  logic         s_tuser,    // kind[0]
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata     // even_word[61:0], odd_word[123:62], zero pad
);
    import tpse_pkg::*;

    // Configuration registers
    logic  invert_pairs_reg;
    logic  rgb_lane_order_reg;
    logic  cfg_wr;
    cfg_t  cfg;

    // Input stage
    logic        in_valid_reg,  in_valid_next;
    logic        in_kind_reg;
    logic [23:0] in_color_reg;
    logic [1:0]  in_code_reg;

    // Result stage
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_even_reg;
    logic [WORD_W-1:0]   out_odd_reg;
    logic [WORD_W-1:0]   even_next;
    logic [WORD_W-1:0]   odd_next;

    logic s_fire;
    logic advance;

    //------------------------------------------------------------------
    // APB
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_pairs_reg   <= 1'b0;
            rgb_lane_order_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_INVERT_PAIRS:   invert_pairs_reg   <= pwdata[0];
                REG_RGB_LANE_ORDER: rgb_lane_order_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_INVERT_PAIRS:   prdata = {31'd0, invert_pairs_reg};
            REG_RGB_LANE_ORDER: prdata = {31'd0, rgb_lane_order_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.invert_pairs   = invert_pairs_reg;
    assign cfg.rgb_lane_order = rgb_lane_order_reg;

    //------------------------------------------------------------------
    // Pipeline control: input stage moves on when the result slot is free
    //------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        priority if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        priority if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_kind_reg  <= s_tuser;
            in_color_reg <= s_tdata[23:0];
            in_code_reg  <= s_tdata[25:24];
        end
        if (advance)
        begin
            out_even_reg <= even_next;
            out_odd_reg  <= odd_next;
        end
    end

    //------------------------------------------------------------------
    // Encode
    //------------------------------------------------------------------
    tpse_word_builder u_word_builder (
        .kind      (in_kind_reg),
        .color     (in_color_reg),
        .ctrl_code (in_code_reg),
        .cfg       (cfg),
        .even_word (even_next),
        .odd_word  (odd_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_odd_reg, out_even_reg};

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    `TPSE_ASSERT_IMP(a_odd_even_rel, m_tvalid,
        ((out_even_reg ^ out_odd_reg) == ODD_MASK) || (out_even_reg == out_odd_reg),
        "odd word is neither even word nor even word with mask")
    `TPSE_ASSERT_IMP(a_gap_bits_zero, m_tvalid, out_even_reg[31:30] == 2'b00,
        "even word gap bits not zero")
    `TPSE_ASSERT_IMP(a_ready_when_empty, !in_valid_reg, s_tready,
        "input stage empty but not ready")
    `TPSE_ASSERT_NXT(a_accept_fills, s_fire, in_valid_reg,
        "accepted word did not reach the input stage")
    `TPSE_ASSERT_NXT(a_advance_fills, advance, m_tvalid,
        "advanced word did not reach the result register")

endmodule
